// ----- hdl/gwm_pkg.sv -----
// Package for the glob wildcard matcher: sizes, wildcard codes, register
// indexes and the types shared by the cells, the chain and the register file.
// No dependencies.
`timescale 1ns / 1ps

package gwm_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int LEN_W       = 6;
    localparam int SET_W       = PATTERN_MAX + 1;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int DATA_W      = 64;

    localparam logic [7:0] WILD_ONE = 8'h3F;
    localparam logic [7:0] WILD_RUN = 8'h2A;

    localparam logic [IDX_W-1:0] REG_LENGTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_BYTES_0  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BYTES_8  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BYTES_16 = 3'd3;
    localparam logic [IDX_W-1:0] REG_BYTES_24 = 3'd4;

    typedef logic [PATTERN_MAX-1:0][7:0] pat_bytes_t;

    typedef struct packed {
        logic closed;
        logic run_link;
        logic advance;
    } cell_out_t;

endpackage

// ----- hdl/gwm_text_if.sv -----
// Input channel of the glob wildcard matcher: one string byte or an end mark.
// Depends on nothing.
`timescale 1ns / 1ps

interface gwm_text_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] text_byte;

    modport source (output valid, output mode, output text_byte, input ready);
    modport sink   (input valid, input mode, input text_byte, output ready);
endinterface

// ----- hdl/gwm_result_if.sv -----
// Output channel of the glob wildcard matcher: one match flag per string.
// Depends on nothing.
`timescale 1ns / 1ps

interface gwm_result_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink   (input valid, input matched, output ready);
endinterface

// ----- hdl/gwm_cell.sv -----
// One pattern position of the matcher: holds its reachable bit, closes over a
// run wildcard and hands links to the next position. Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_cell
    import gwm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       seed,
    input  logic       active,
    input  logic [7:0] pat_byte,
    input  logic [7:0] text_byte,
    input  logic       link_in,
    input  logic       advance_in,
    input  logic       step,
    input  logic       restart,
    output cell_out_t  cell_out
);

    logic reach_reg;
    logic reach_next;
    logic closed;
    logic is_run;
    logic hit;

    assign is_run = (pat_byte == WILD_RUN);
    assign hit    = (pat_byte == WILD_ONE) || (pat_byte == text_byte);
    assign closed = reach_reg | link_in;

    assign cell_out.closed   = closed;
    assign cell_out.run_link = closed & active & is_run;
    assign cell_out.advance  = closed & active & ~is_run & hit;

    always_comb
    begin
        reach_next = reach_reg;
        if (restart)
        begin
            reach_next = seed;
        end
        else if (step)
        begin
            reach_next = (closed & active & is_run) | advance_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= seed;
        end
        else
        begin
            reach_reg <= reach_next;
        end
    end

endmodule

// ----- hdl/gwm_chain.sv -----
// Row of position cells plus the final position; gives the closed set bit at
// the pattern length. Depends on gwm_pkg and gwm_cell.
`timescale 1ns / 1ps

module gwm_chain
    import gwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  pat_bytes_t       pat_bytes,
    input  logic [LEN_W-1:0] pat_len,
    input  logic [7:0]       text_byte,
    input  logic             step,
    input  logic             restart,
    output logic             matched
);

    cell_out_t        cell_out [PATTERN_MAX];
    logic [SET_W-1:0] closed_vec;
    logic             last_reg;
    logic             last_next;

    genvar p;
    generate
        for (p = 0; p < PATTERN_MAX; p++)
        begin : g_cell
            logic link_in;
            logic advance_in;

            if (p == 0)
            begin : g_first
                assign link_in    = 1'b0;
                assign advance_in = 1'b0;
            end
            else
            begin : g_rest
                assign link_in    = cell_out[p-1].run_link;
                assign advance_in = cell_out[p-1].advance;
            end

            gwm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .seed       ((p == 0) ? 1'b1 : 1'b0),
                .active     (LEN_W'(p) < pat_len),
                .pat_byte   (pat_bytes[p]),
                .text_byte  (text_byte),
                .link_in    (link_in),
                .advance_in (advance_in),
                .step       (step),
                .restart    (restart),
                .cell_out   (cell_out[p])
            );

            assign closed_vec[p] = cell_out[p].closed;
        end
    endgenerate

    assign closed_vec[PATTERN_MAX] = last_reg | cell_out[PATTERN_MAX-1].run_link;
    assign matched                 = closed_vec[pat_len];

    always_comb
    begin
        last_next = last_reg;
        if (restart)
        begin
            last_next = 1'b0;
        end
        else if (step)
        begin
            last_next = cell_out[PATTERN_MAX-1].advance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 1'b0;
        end
        else
        begin
            last_reg <= last_next;
        end
    end

endmodule

// ----- hdl/gwm_cfg.sv -----
// APB-style register file for the pattern length and pattern bytes.
// Depends on gwm_pkg.
`timescale 1ns / 1ps

module gwm_cfg
    import gwm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output pat_bytes_t        pat_bytes,
    output logic [LEN_W-1:0]  pat_len
);

    logic [LEN_W-1:0]  length_reg;
    logic [DATA_W-1:0] words_reg [4];
    logic [IDX_W-1:0]  idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
    assign wr_en  = psel & penable & pwrite;

    assign pat_len = (length_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : length_reg;
    assign pat_bytes = {words_reg[3], words_reg[2], words_reg[1], words_reg[0]};

    always_comb
    begin
        unique case (idx)
            REG_LENGTH:   prdata = {{(DATA_W-LEN_W){1'b0}}, length_reg};
            REG_BYTES_0:  prdata = words_reg[0];
            REG_BYTES_8:  prdata = words_reg[1];
            REG_BYTES_16: prdata = words_reg[2];
            REG_BYTES_24: prdata = words_reg[3];
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            words_reg[0] <= '0;
            words_reg[1] <= '0;
            words_reg[2] <= '0;
            words_reg[3] <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LENGTH:   length_reg   <= pwdata[LEN_W-1:0];
                REG_BYTES_0:  words_reg[0] <= pwdata;
                REG_BYTES_8:  words_reg[1] <= pwdata;
                REG_BYTES_16: words_reg[2] <= pwdata;
                REG_BYTES_24: words_reg[3] <= pwdata;
                default:      ;
            endcase
        end
    end

endmodule

// ----- hdl/glob_wildcard_matcher.sv -----
// Top level of the glob wildcard matcher: register file, cell chain and
// result register. Depends on gwm_pkg, gwm_text_if, gwm_result_if, gwm_cfg,
// gwm_chain.
//
//   channel    | dir | payload              | transaction
//   text_ch    | in  | mode, text_byte      | one string byte or end of string
//   result_ch  | out | matched              | one flag per end of string
//   apb        | in  | paddr, pwdata/prdata | register write or read, 64 bits
//
// One transaction per cycle while ready is high; a byte updates every cell's
// reachable bit in the cycle it is taken, with the star closure rippling along
// the row of cells. An end transaction loads the result register at the edge
// that takes it; the flag is offered from the next cycle. text_ch stays ready
// while that register is empty or being drained.
// Reset leaves only position zero reachable, no result pending, config zero.
`timescale 1ns / 1ps

module glob_wildcard_matcher
    import gwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    gwm_text_if.sink            text_ch,
    gwm_result_if.source        result_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    pat_bytes_t       pat_bytes;
    logic [LEN_W-1:0] pat_len;
    logic             take;
    logic             step;
    logic             restart;
    logic             matched;
    logic             valid_reg;
    logic             valid_next;
    logic             matched_reg;

    gwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pat_bytes (pat_bytes),
        .pat_len   (pat_len)
    );

    assign text_ch.ready = ~valid_reg | result_ch.ready;
    assign take          = text_ch.valid & text_ch.ready;
    assign step          = take & ~text_ch.mode;
    assign restart       = take & text_ch.mode;

    gwm_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .pat_bytes (pat_bytes),
        .pat_len   (pat_len),
        .text_byte (text_ch.text_byte),
        .step      (step),
        .restart   (restart),
        .matched   (matched)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (restart)
        begin
            valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (restart)
        begin
            matched_reg <= matched;
        end
    end

    assign result_ch.valid   = valid_reg;
    assign result_ch.matched = matched_reg;

endmodule

// ----- tb/sv/tb_glob_wildcard_matcher.sv -----
// Testbench for glob_wildcard_matcher: a directed table, then random patterns and strings
// checked against a reachable-position predictor. Depends on gwm_pkg, gwm_text_if,
// gwm_result_if and the glob_wildcard_matcher RTL.
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher;
    import gwm_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int IDLE_PCT      = 27;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int PLAN_ROWS     = 39;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_END  = 1'b1;

    localparam logic [IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

    localparam logic [63:0] ALL_STARS = 64'h2A2A_2A2A_2A2A_2A2A;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {ROW_WRITE, ROW_BYTE, ROW_END} row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [IDX_W-1:0] reg_idx;
        logic [63:0]      wdata;
        logic [7:0]       text_byte;
        logic             typed;
        logic             matched;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    gwm_text_if   text_ch();
    gwm_result_if result_ch();

    logic [LEN_W-1:0]  pat_len_reg;
    logic [63:0]       pat_words [4];
    logic [SET_W-1:0]  live_positions;
    logic              match_flags_due [$];
    logic [7:0]        text_buf [$];
    int                mismatch_count;
    int                idle_pct;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b1},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h61, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b0},
        '{ROW_WRITE, REG_LENGTH,       64'd3,                 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_0,      64'h0000_0000_0063_3F61, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h61, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h62, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h63, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b1},
        '{ROW_WRITE, REG_LENGTH,       64'd1,                 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_0,      64'h2A,                8'h00, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b1},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'hFF, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b1},
        '{ROW_WRITE, REG_LENGTH,       64'h3F,                8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_0,      ALL_STARS,             8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_8,      ALL_STARS,             8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_16,     ALL_STARS,             8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_24,     ALL_STARS,             8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h00, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b1},
        '{ROW_WRITE, REG_LENGTH,       64'd32,                8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_24,     ALL_ONES,              8'h00, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b0},
        '{ROW_WRITE, REG_LENGTH,       64'd2,                 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_0,      64'h6261,              8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h61, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_0,      64'h7861,              8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h78, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b0, 1'b0},
        '{ROW_WRITE, REG_BYTES_0,      64'h6261,              8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h7A, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h61, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h62, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b0},
        '{ROW_WRITE, REG_UNUSED_FIRST, 64'h3F3F_3F3F_3F3F_3F3F, 8'h00, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h61, 1'b0, 1'b0},
        '{ROW_BYTE,  REG_LENGTH,       64'h0,                 8'h62, 1'b0, 1'b0},
        '{ROW_END,   REG_LENGTH,       64'h0,                 8'h00, 1'b1, 1'b1}
    };

    glob_wildcard_matcher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_ch   (text_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #(CLK_HALF_NS) clk = 1'b1;
        #(CLK_HALF_NS) clk = 1'b0;
    end

    function automatic int active_length();
        return (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len_reg);
    endfunction

    function automatic logic [7:0] pattern_byte(input int p);
        return pat_words[p / 8][8 * (p % 8) +: 8];
    endfunction

    function automatic logic [SET_W-1:0] close_over_stars(input logic [SET_W-1:0] set,
                                                          input int len);
        logic [SET_W-1:0] s;
        s = set;
        for (int p = 0; p < len; p++)
        begin
            if (s[p] && pattern_byte(p) == WILD_RUN)
                s[p + 1] = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [SET_W-1:0] advance_positions(input logic [SET_W-1:0] cur,
                                                           input int len,
                                                           input logic [7:0] c);
        logic [SET_W-1:0] nxt;
        logic [7:0]       pb;
        nxt = '0;
        for (int p = 0; p < len; p++)
        begin
            if (cur[p])
            begin
                pb = pattern_byte(p);
                if (pb == WILD_RUN)
                    nxt[p] = 1'b1;
                else if (pb == WILD_ONE || pb == c)
                    nxt[p + 1] = 1'b1;
            end
        end
        return nxt;
    endfunction

    function automatic logic [7:0] random_char();
        if ($urandom_range(7) == 0)
            return 8'($urandom);
        return 8'h61 + 8'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pattern_symbol();
        case ($urandom_range(9)) inside
            0, 1:    return WILD_RUN;
            2:       return WILD_ONE;
            3:       return 8'($urandom);
            default: return 8'h61 + 8'($urandom_range(2));
        endcase
    endfunction

    function automatic void add_text(input logic [7:0] ch);
        text_buf.insert(text_buf.size(), ch);
    endfunction

    task automatic drain_results();
        text_ch.valid <= 1'b0;
        @(posedge clk);
        while (match_flags_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [63:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LENGTH:   pat_len_reg  = value[LEN_W-1:0];
            REG_BYTES_0:  pat_words[0] = value;
            REG_BYTES_8:  pat_words[1] = value;
            REG_BYTES_16: pat_words[2] = value;
            REG_BYTES_24: pat_words[3] = value;
            default:      ;
        endcase
    endtask

    task automatic send_item(input logic mode, input logic [7:0] data,
                             input logic typed, input logic typed_flag);
        int               len;
        logic [SET_W-1:0] cur;
        while ($urandom_range(99) < idle_pct)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.mode      <= mode;
        text_ch.text_byte <= data;
        do @(posedge clk); while (!text_ch.ready);
        len = active_length();
        cur = close_over_stars(live_positions, len);
        if (mode == MODE_END)
        begin
            match_flags_due.insert(match_flags_due.size(), typed ? typed_flag : cur[len]);
            live_positions = SET_W'(1);
        end
        else
            live_positions = advance_positions(cur, len, data);
    endtask

    task automatic load_random_pattern();
        int          n;
        logic [7:0]  pb [PATTERN_MAX];
        logic [63:0] word;
        case ($urandom_range(9))
            0:       n = 0;
            1:       n = $urandom_range(33, 63);
            2:       n = PATTERN_MAX;
            3:       n = $urandom_range(9, 31);
            default: n = $urandom_range(1, 8);
        endcase
        for (int i = 0; i < PATTERN_MAX; i++)
            pb[i] = (i < n) ? pattern_symbol() : 8'($urandom);
        write_reg(REG_LENGTH, {26'($urandom), 32'($urandom), 6'(n)});
        for (int w = 0; w < 4; w++)
        begin
            for (int k = 0; k < 8; k++)
                word[8 * k +: 8] = pb[8 * w + k];
            write_reg(REG_BYTES_0 + IDX_W'(w), word);
        end
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED_FIRST + IDX_W'($urandom_range(2)), {$urandom, $urandom});
    endtask

    task automatic build_text();
        int len;
        len = active_length();
        text_buf.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(12)) add_text(random_char());
        end
        else
        begin
            for (int p = 0; p < len; p++)
            begin
                if (pattern_byte(p) == WILD_RUN)
                    repeat ($urandom_range(3)) add_text(random_char());
                else if (pattern_byte(p) == WILD_ONE)
                    add_text(random_char());
                else
                    add_text(pattern_byte(p));
            end
            case ($urandom_range(5))
                0:
                begin
                    if (text_buf.size() != 0)
                        text_buf[$urandom_range(text_buf.size() - 1)] = random_char();
                end
                1:
                begin
                    if (text_buf.size() != 0)
                        text_buf.delete($urandom_range(text_buf.size() - 1));
                end
                2:       text_buf.insert($urandom_range(text_buf.size()), random_char());
                default: ;
            endcase
        end
    endtask

    always @(posedge clk)
    begin : result_check
        logic due_flag;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (match_flags_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual matched=%0b",
                             $time, result_ch.matched);
                    mismatch_count++;
                end
                else
                begin
                    due_flag = match_flags_due.pop_front();
                    if (result_ch.matched !== due_flag)
                    begin
                        $display("%0t: matched mismatch, expected %0b, actual %0b",
                                 $time, due_flag, result_ch.matched);
                        mismatch_count++;
                    end
                end
            end
            result_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int strings_left;
        int mid;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        text_ch.valid     = 1'b0;
        text_ch.mode      = MODE_BYTE;
        text_ch.text_byte = 8'h00;
        result_ch.ready   = 1'b0;
        pat_len_reg       = '0;
        for (int w = 0; w < 4; w++)
            pat_words[w] = '0;
        live_positions    = SET_W'(1);
        mismatch_count    = 0;
        idle_pct          = IDLE_PCT;
        sent              = 0;
        strings_left      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            case (plan[r].kind)
                ROW_WRITE: write_reg(plan[r].reg_idx, plan[r].wdata);
                ROW_BYTE:  send_item(MODE_BYTE, plan[r].text_byte, 1'b0, 1'b0);
                default:   send_item(MODE_END, plan[r].text_byte, plan[r].typed,
                                     plan[r].matched);
            endcase
        end

        while (sent < RANDOM_ITEMS)
        begin
            idle_pct = (sent >= 400 && sent < 700) ? 0 : IDLE_PCT;
            if (strings_left == 0)
            begin
                load_random_pattern();
                strings_left = $urandom_range(5, 20);
            end
            build_text();
            mid = ($urandom_range(19) == 0) ? $urandom_range(text_buf.size()) : -1;
            for (int i = 0; i < text_buf.size(); i++)
            begin
                if (i == mid)
                    write_reg(REG_LENGTH, 64'($urandom_range(PATTERN_MAX)));
                send_item(MODE_BYTE, text_buf[i], 1'b0, 1'b0);
                sent++;
            end
            send_item(MODE_END, 8'($urandom), 1'b0, 1'b0);
            sent++;
            strings_left--;
            if ($urandom_range(24) == 0)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
